// ===== rtl/brfp_pkg.sv =====
// Shared types and constants for the byte ring FIFO with peek.
package brfp_pkg;

   localparam int DEPTH_DEF = 1024;   // built storage depth
   localparam int CFG_W     = 11;     // capacity register width
   localparam int BYTE_W    = 8;
   localparam int OFF_W     = 10;
   localparam int CNT_OUT_W = 11;
   localparam int DROP_W    = 16;
   localparam logic [DROP_W-1:0] DROP_MAX = '1;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_PEEK  = 2'd2,
      OP_CLEAR = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type         opcode;
      logic [BYTE_W-1:0]  data_in;
      logic [OFF_W-1:0]   offset;
      logic               first_in_call;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]    data_out;
      logic                 valid_res;
      logic [CNT_OUT_W-1:0] count;
      logic [DROP_W-1:0]    overflow_count;
      logic                 is_full;
      logic                 is_empty;
   } rsp_type;

endpackage

// ===== rtl/byte_ring_fifo_with_peek.sv =====
// Top level: byte ring FIFO with push, pop, peek and clear operations.
//
// One operation is taken in every clock cycle: busy is always low and start
// alone marks a transfer. Each operation gives exactly one result, shown on
// rsp_item for one cycle with rsp_valid high, after it has passed the request
// register and then the result register, which the registered read of the
// byte storage feeds in parallel. Results come out in operation order
// at one per cycle, so the receiver never needs to stall. Storage is a
// DEPTH x 8 RAM with no reset; pops and peeks only reach bytes that were
// pushed, so no clearing pass is run and the block is ready right after
// reset. The capacity register is always ready; a write clamps the value to
// 1..DEPTH and empties the queue. It is meant to be written while no
// operation is in flight.
module byte_ring_fifo_with_peek
   import brfp_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   // operation channel
   input  logic             start,
   output logic             busy,
   input  req_type          req_item,
   // result channel
   output logic             rsp_valid,
   output rsp_type          rsp_item,
   // capacity register
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CFG_W-1:0] csr_data
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   // wide enough for head + offset and for the count output
   localparam int SUM_W  = ((CNT_W > OFF_W) ? CNT_W : OFF_W) + 1;
   // wide enough to compare a written value against DEPTH
   localparam int CLM_W  = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

   // request register
   logic    item_vld_ff;
   req_type item_ff;

   // queue state
   logic [ADDR_W-1:0] wp_ff, wp_in;
   logic [ADDR_W-1:0] rp_ff, rp_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  cap_ff, cap_in;
   logic [DROP_W-1:0] drop_ff, drop_in;
   logic              bhd_ff, bhd_in;

   // result register (data byte comes from the RAM read register)
   logic    rsp_vld_ff;
   rsp_type rsp_meta_ff, rsp_meta_in;
   logic    rd_hit_ff, rd_hit_in;

   // RAM ports
   logic              ram_wr_en;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [BYTE_W-1:0] ram_rd_data;

   // datapath helpers
   logic [CNT_W-1:0]  cap_m1;
   logic [ADDR_W-1:0] wp_adv, rp_adv;
   logic [SUM_W-1:0]  peek_sum, peek_idx, fill_wide;
   logic              q_full, q_empty, off_ok, bhd_eff;
   logic [CLM_W-1:0]  cfg_ext, cfg_clamp;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------
   // Request register: every start is a transfer.
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
      end else begin
         item_vld_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start & ~busy) begin
         item_ff <= req_item;
      end
   end

   // ---------------------------------------------------------------
   // Pointer math. Pointers wrap at capacity, not at DEPTH.
   // ---------------------------------------------------------------
   assign cap_m1  = cap_ff - CNT_W'(1);
   assign wp_adv  = (CNT_W'(wp_ff) == cap_m1) ? '0 : wp_ff + ADDR_W'(1);
   assign rp_adv  = (CNT_W'(rp_ff) == cap_m1) ? '0 : rp_ff + ADDR_W'(1);
   assign q_full  = (fill_ff == cap_ff);
   assign q_empty = (fill_ff == '0);

   // head + offset is below 2*capacity whenever the peek is in range,
   // so one conditional subtract folds it back
   assign peek_sum = SUM_W'(rp_ff) + SUM_W'(item_ff.offset);
   assign peek_idx = (peek_sum >= SUM_W'(cap_ff)) ? peek_sum - SUM_W'(cap_ff) : peek_sum;
   assign off_ok   = SUM_W'(item_ff.offset) < SUM_W'(fill_ff);

   // batch start forgets earlier drops before the push is handled
   assign bhd_eff = bhd_ff & ~item_ff.first_in_call;

   // capacity clamp to 1..DEPTH
   assign cfg_ext = CLM_W'(csr_data);
   always_comb begin
      cfg_clamp = cfg_ext;
      priority if (cfg_ext == '0) begin
         cfg_clamp = CLM_W'(1);
      end else if (cfg_ext > CLM_W'(DEPTH)) begin
         cfg_clamp = CLM_W'(DEPTH);
      end
   end

   // ---------------------------------------------------------------
   // Operation decode and next state.
   // ---------------------------------------------------------------
   always_comb begin
      wp_in       = wp_ff;
      rp_in       = rp_ff;
      fill_in     = fill_ff;
      cap_in      = cap_ff;
      drop_in     = drop_ff;
      bhd_in      = bhd_ff;
      ram_wr_en   = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = rp_ff;
      rd_hit_in   = 1'b0;
      rsp_meta_in = '0;

      if (item_vld_ff) begin
         unique case (item_ff.opcode)
            OP_PUSH: begin
               bhd_in = bhd_eff;
               if (!q_full) begin
                  ram_wr_en            = 1'b1;
                  wp_in                = wp_adv;
                  fill_in              = fill_ff + CNT_W'(1);
                  rsp_meta_in.valid_res = 1'b1;
               end else if (!bhd_eff) begin
                  drop_in = DROP_W'(1);
                  bhd_in  = 1'b1;
               end else if (drop_ff != DROP_MAX) begin
                  drop_in = drop_ff + DROP_W'(1);
               end
            end
            OP_POP: begin
               if (!q_empty) begin
                  ram_rd_en            = 1'b1;
                  rp_in                = rp_adv;
                  fill_in              = fill_ff - CNT_W'(1);
                  rd_hit_in            = 1'b1;
                  rsp_meta_in.valid_res = 1'b1;
               end
            end
            OP_PEEK: begin
               if (off_ok) begin
                  ram_rd_en            = 1'b1;
                  ram_rd_addr          = peek_idx[ADDR_W-1:0];
                  rd_hit_in            = 1'b1;
                  rsp_meta_in.valid_res = 1'b1;
               end
            end
            OP_CLEAR: begin
               wp_in   = '0;
               rp_in   = '0;
               fill_in = '0;
               drop_in = '0;
               bhd_in  = 1'b0;
            end
            default: begin
            end
         endcase
      end

      // capacity write empties the queue
      if (csr_valid && csr_ready) begin
         cap_in  = cfg_clamp[CNT_W-1:0];
         wp_in   = '0;
         rp_in   = '0;
         fill_in = '0;
         drop_in = '0;
         bhd_in  = 1'b0;
      end

      fill_wide                  = SUM_W'(fill_in);
      rsp_meta_in.count          = fill_wide[CNT_OUT_W-1:0];
      rsp_meta_in.overflow_count = drop_in;
      rsp_meta_in.is_full        = (fill_in == cap_ff);
      rsp_meta_in.is_empty       = (fill_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         rp_ff      <= '0;
         fill_ff    <= '0;
         cap_ff     <= CNT_W'(DEPTH);
         drop_ff    <= '0;
         bhd_ff     <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         wp_ff      <= wp_in;
         rp_ff      <= rp_in;
         fill_ff    <= fill_in;
         cap_ff     <= cap_in;
         drop_ff    <= drop_in;
         bhd_ff     <= bhd_in;
         rsp_vld_ff <= item_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_meta_ff <= rsp_meta_in;
      rd_hit_ff   <= rd_hit_in;
   end

   // ---------------------------------------------------------------
   // Byte storage
   // ---------------------------------------------------------------
   brfp_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wp_ff),
      .wr_data (item_ff.data_in),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------
   // Result port: data byte only for a pop or peek that hit.
   // ---------------------------------------------------------------
   always_comb begin
      rsp_item          = rsp_meta_ff;
      rsp_item.data_out = rd_hit_ff ? ram_rd_data : '0;
   end
   assign rsp_valid = rsp_vld_ff;

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   a_fill_le_cap: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= cap_ff)
      else $error("fill level above capacity");

   a_ptr_in_ring: assert property (@(posedge clock) disable iff (reset)
      (CNT_W'(wp_ff) < cap_ff) && (CNT_W'(rp_ff) < cap_ff))
      else $error("pointer outside capacity");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("transfer without result");

   a_hit_is_valid: assert property (@(posedge clock) disable iff (reset)
      (item_vld_ff && ram_rd_en) |=> (rsp_valid && rsp_item.valid_res && rd_hit_ff))
      else $error("storage read without valid result");

endmodule

// ===== rtl/brfp_ram.sv =====
// Byte storage: one write port, one read port with registered read data.
module brfp_ram
   import brfp_pkg::*;
#(
   parameter int DEPTH  = DEPTH_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
